// ----- hdl/crru_pkg.sv -----
// shared constants, types and binomial table builder for the combinadic rank/unrank unit
package crru_pkg;

	localparam int MaxPositions = 64;
	localparam int MaxSetBits   = 18;
	localparam int RowLen       = MaxSetBits + 1;
	localparam int RomDepth     = (MaxPositions + 1) * RowLen;
	localparam int AddrW        = $clog2(RomDepth);
	localparam int ValW         = 52;
	localparam int WidW         = 6;
	localparam int RomW         = ValW + WidW;
	localparam int OperandW     = 64;
	localparam int CountW       = 7;
	localparam int StatusW      = 2;
	localparam int InFieldsW    = OperandW + 2 * CountW;
	localparam int InDataW      = ((InFieldsW + 7) / 8) * 8;
	localparam int OutFieldsW   = OperandW + CountW + StatusW;
	localparam int OutDataW     = ((OutFieldsW + 7) / 8) * 8;

	typedef enum logic {
		REQ_RANK   = 1'b0,
		REQ_UNRANK = 1'b1
	} req_t;

	typedef enum logic [StatusW-1:0] {
		STAT_OK       = 2'd0,
		STAT_RANGE    = 2'd1,
		STAT_RANK_BIG = 2'd2,
		STAT_POPCOUNT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_UNRANK,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_LOOKUP,
		OP_CHECK,
		OP_SCAN,
		OP_DRAIN,
		OP_UNRANK,
		OP_OUT
	} dp_op_t;

	// datapath flags seen by the controller
	typedef struct packed {
		logic range_err;
		logic early_done;
		logic unrank_req;
		logic scan_last;
		logic unrank_last;
		logic out_free;
	} dp_stat_t;

	typedef logic [RomW-1:0] rom_arr_t [RomDepth];

	// ceil(log2 c), zero for c of 0 or 1
	function automatic logic [WidW-1:0] width_of(logic [ValW-1:0] c);
		logic [ValW-1:0] v;
		int w;
		w = 0;
		v = c - ValW'(1);
		if (c > ValW'(1)) begin
			for (int i = 0; i < ValW; i++) begin
				if (v[i]) begin
					w = i + 1;
				end
			end
		end
		return WidW'(w);
	endfunction

	// pascal's triangle, each entry with its rank width in the top bits
	function automatic rom_arr_t build_rom();
		rom_arr_t rom;
		logic [ValW-1:0] prev [RowLen];
		logic [ValW-1:0] cur [RowLen];
		for (int k = 0; k < RowLen; k++) begin
			prev[k] = '0;
		end
		for (int n = 0; n <= MaxPositions; n++) begin
			for (int k = 0; k < RowLen; k++) begin
				if (k > n) begin
					cur[k] = '0;
				end else if (k == 0 || k == n) begin
					cur[k] = ValW'(1);
				end else begin
					cur[k] = prev[k-1] + prev[k];
				end
				rom[n * RowLen + k] = {width_of(cur[k]), cur[k]};
			end
			for (int k = 0; k < RowLen; k++) begin
				prev[k] = cur[k];
			end
		end
		return rom;
	endfunction

	function automatic logic [AddrW-1:0] rom_addr_of(logic [CountW-1:0] pos,
			logic [CountW-1:0] k);
		return AddrW'(int'(pos) * RowLen + int'(k));
	endfunction

endpackage

// ----- hdl/combinadic_rank_unrank_unit.sv -----
// top level of the combinadic rank/unrank unit
//
// One request word comes in on the s_ channel, one result word leaves on the m_ channel.
// s_tuser selects the request: 0 ranks the pattern in s_tdata, 1 unranks the rank in s_tdata.
// Each result carries the rank or pattern, the rank width ceil(log2 C(n,k)) and a status code
// (ok, n or k out of range, rank too large, popcount mismatch); on error the value is zero.
// A rank request walks the n pattern positions one per cycle, reading the binomial rom for
// each set bit; a drain state adds the last rom read before the result is registered.
// An unrank request walks down from position n-1, one rom probe per cycle, until all k bits
// are placed. Range, stray bit and rank checks end a request early in the lookup or check state.
// The rom has one read port with registered output; that single port paces the walk.
// One request is in flight at a time; s_tready is high while the unit waits for a request,
// so the next word is taken even while the previous result still waits on m_tready.
// A stalled receiver holds the finished result in the output register and the unit waits
// with the next result until that register is free.
// The binomial table is constant and needs no fill time. arst_n clears the sequencer and the
// output valid; the first request may follow in the cycle after reset is released.
module combinadic_rank_unrank_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// operand_value, position_count, set_count, zero fill
	input  logic [crru_pkg::InDataW-1:0]  s_tdata,
	// req_type
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_value, rank_width, status, zero fill
	output logic [crru_pkg::OutDataW-1:0] m_tdata
);

	crru_pkg::dp_op_t   op;
	crru_pkg::dp_stat_t st;

	crru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.op       (op)
	);

	crru_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- hdl/crru_ctrl.sv -----
// sequencing state machine for the combinadic rank/unrank unit
module crru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  crru_pkg::dp_stat_t st,
	output crru_pkg::dp_op_t   op
);

	crru_pkg::state_t state_q;
	crru_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crru_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		s_tready = 1'b0;
		op       = crru_pkg::OP_HOLD;
		case (state_q)
			crru_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op       = crru_pkg::OP_LOAD;
					state_nx = crru_pkg::ST_LOOKUP;
				end
			end
			crru_pkg::ST_LOOKUP: begin
				op       = crru_pkg::OP_LOOKUP;
				state_nx = st.range_err ? crru_pkg::ST_FINISH : crru_pkg::ST_CHECK;
			end
			crru_pkg::ST_CHECK: begin
				op = crru_pkg::OP_CHECK;
				if (st.early_done) begin
					state_nx = crru_pkg::ST_FINISH;
				end else if (st.unrank_req) begin
					state_nx = crru_pkg::ST_UNRANK;
				end else begin
					state_nx = crru_pkg::ST_SCAN;
				end
			end
			crru_pkg::ST_SCAN: begin
				op = crru_pkg::OP_SCAN;
				if (st.scan_last) begin
					state_nx = crru_pkg::ST_DRAIN;
				end
			end
			crru_pkg::ST_DRAIN: begin
				op       = crru_pkg::OP_DRAIN;
				state_nx = crru_pkg::ST_FINISH;
			end
			crru_pkg::ST_UNRANK: begin
				op = crru_pkg::OP_UNRANK;
				if (st.unrank_last) begin
					state_nx = crru_pkg::ST_FINISH;
				end
			end
			crru_pkg::ST_FINISH: begin
				if (st.out_free) begin
					op       = crru_pkg::OP_OUT;
					state_nx = crru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = crru_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/crru_datapath.sv -----
// operand registers, binomial rom, rank accumulator, unrank walker and output register
module crru_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crru_pkg::dp_op_t              op,
	output crru_pkg::dp_stat_t            st,
	input  logic [crru_pkg::InDataW-1:0]  s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [crru_pkg::OutDataW-1:0] m_tdata
);

	localparam crru_pkg::rom_arr_t Rom = crru_pkg::build_rom();

	crru_pkg::req_t                     type_q;
	logic [crru_pkg::OperandW-1:0]      opnd_q;
	logic [crru_pkg::CountW-1:0]        n_q;
	logic [crru_pkg::CountW-1:0]        k_q;
	logic [crru_pkg::CountW-1:0]        pos_q;
	logic [crru_pkg::CountW-1:0]        idx_q;
	logic [crru_pkg::ValW-1:0]          acc_q;
	logic [crru_pkg::ValW-1:0]          rem_q;
	logic [crru_pkg::OperandW-1:0]      pat_q;
	logic [crru_pkg::WidW-1:0]          width_q;
	crru_pkg::status_t                  status_q;
	logic                               add_s1;
	logic                               m_valid_q;
	logic [crru_pkg::OutDataW-1:0]      m_data_q;

	logic [crru_pkg::RomW-1:0]          rom_q;
	logic [crru_pkg::AddrW-1:0]         rom_addr;
	logic [crru_pkg::ValW-1:0]          rom_val;
	logic [crru_pkg::WidW-1:0]          rom_wid;

	logic                               range_err;
	logic                               stray;
	logic                               big;
	logic                               inc_ok;
	logic                               scan_add;
	logic                               take;
	logic [crru_pkg::CountW-1:0]        idx_inc;
	logic [crru_pkg::CountW-1:0]        left_nx;
	logic [crru_pkg::CountW-1:0]        pos_dn;
	crru_pkg::status_t                  fin_status;
	logic [crru_pkg::OperandW-1:0]      fin_result;

	assign {rom_wid, rom_val} = rom_q;

	assign range_err = (n_q > crru_pkg::CountW'(crru_pkg::MaxPositions))
		|| (k_q > crru_pkg::CountW'(crru_pkg::MaxSetBits)) || (k_q > n_q);
	// bit 6 of n set means all 64 positions are in use
	assign stray   = n_q[crru_pkg::CountW-1] ? 1'b0
		: ((opnd_q >> n_q[crru_pkg::CountW-2:0]) != '0);
	assign big     = opnd_q >= crru_pkg::OperandW'(rom_val);
	assign idx_inc = idx_q + crru_pkg::CountW'(opnd_q[0]);
	assign inc_ok  = idx_inc <= crru_pkg::CountW'(crru_pkg::MaxSetBits);
	assign scan_add = (op == crru_pkg::OP_SCAN) && opnd_q[0] && inc_ok;
	assign take    = rom_val <= rem_q;
	assign left_nx = idx_q - crru_pkg::CountW'(take);
	assign pos_dn  = pos_q - crru_pkg::CountW'(1);

	always_comb begin
		rom_addr = '0;
		case (op)
			crru_pkg::OP_LOOKUP: begin
				if (!range_err) begin
					rom_addr = crru_pkg::rom_addr_of(n_q, k_q);
				end
			end
			crru_pkg::OP_CHECK: begin
				// first greedy probe at the top position
				if (k_q != '0) begin
					rom_addr = crru_pkg::rom_addr_of(n_q - crru_pkg::CountW'(1), k_q);
				end
			end
			crru_pkg::OP_SCAN: begin
				if (scan_add) begin
					rom_addr = crru_pkg::rom_addr_of(pos_q, idx_inc);
				end
			end
			crru_pkg::OP_UNRANK: begin
				if (pos_q != '0 && left_nx != '0) begin
					rom_addr = crru_pkg::rom_addr_of(pos_dn, left_nx);
				end
			end
			default: begin
				rom_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rom_q <= Rom[rom_addr];
	end

	always_comb begin
		fin_status = status_q;
		if (status_q == crru_pkg::STAT_OK && type_q == crru_pkg::REQ_RANK && idx_q != k_q) begin
			fin_status = crru_pkg::STAT_POPCOUNT;
		end
		if (fin_status != crru_pkg::STAT_OK) begin
			fin_result = '0;
		end else if (type_q == crru_pkg::REQ_UNRANK) begin
			fin_result = pat_q;
		end else begin
			fin_result = crru_pkg::OperandW'(acc_q);
		end
	end

	assign st.range_err   = range_err;
	assign st.early_done  = (type_q == crru_pkg::REQ_UNRANK) ? (big || k_q == '0)
		: (stray || n_q == '0);
	assign st.unrank_req  = type_q == crru_pkg::REQ_UNRANK;
	assign st.scan_last   = pos_q == n_q - crru_pkg::CountW'(1);
	assign st.unrank_last = pos_q == '0 || left_nx == '0;
	assign st.out_free    = !m_valid_q || m_tready;

	always_ff @(posedge clk) begin
		case (op)
			crru_pkg::OP_LOAD: begin
				opnd_q   <= s_tdata[crru_pkg::OperandW-1:0];
				n_q      <= s_tdata[crru_pkg::OperandW +: crru_pkg::CountW];
				k_q      <= s_tdata[crru_pkg::OperandW + crru_pkg::CountW +: crru_pkg::CountW];
				type_q   <= crru_pkg::req_t'(s_tuser);
				width_q  <= '0;
				status_q <= crru_pkg::STAT_OK;
			end
			crru_pkg::OP_LOOKUP: begin
				status_q <= range_err ? crru_pkg::STAT_RANGE : crru_pkg::STAT_OK;
			end
			crru_pkg::OP_CHECK: begin
				width_q <= rom_wid;
				pos_q   <= '0;
				idx_q   <= '0;
				acc_q   <= '0;
				pat_q   <= '0;
				rem_q   <= opnd_q[crru_pkg::ValW-1:0];
				if (type_q == crru_pkg::REQ_UNRANK) begin
					pos_q <= n_q - crru_pkg::CountW'(1);
					idx_q <= k_q;
					if (big) begin
						status_q <= crru_pkg::STAT_RANK_BIG;
					end
				end else if (stray) begin
					status_q <= crru_pkg::STAT_POPCOUNT;
				end
			end
			crru_pkg::OP_SCAN: begin
				opnd_q <= opnd_q >> 1;
				idx_q  <= idx_inc;
				pos_q  <= pos_q + crru_pkg::CountW'(1);
				if (add_s1) begin
					acc_q <= acc_q + rom_val;
				end
			end
			crru_pkg::OP_DRAIN: begin
				if (add_s1) begin
					acc_q <= acc_q + rom_val;
				end
			end
			crru_pkg::OP_UNRANK: begin
				if (take) begin
					pat_q <= pat_q | (crru_pkg::OperandW'(1) << pos_q[crru_pkg::CountW-2:0]);
					rem_q <= rem_q - rom_val;
				end
				idx_q <= left_nx;
				pos_q <= pos_dn;
			end
			crru_pkg::OP_OUT: begin
				m_data_q <= crru_pkg::OutDataW'({fin_status,
					crru_pkg::CountW'(width_q), fin_result});
			end
			default: begin
			end
		endcase
	end

	// add flag follows the rom read it goes with
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			add_s1 <= scan_add;
			if (op == crru_pkg::OP_OUT) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_unrank_popcount: assert property (@(posedge clk) disable iff (!arst_n)
		(op == crru_pkg::OP_OUT && fin_status == crru_pkg::STAT_OK
			&& type_q == crru_pkg::REQ_UNRANK) |-> ($countones(pat_q) == int'(k_q)))
		else $error("unrank pattern does not hold k set bits");

	a_unrank_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(op == crru_pkg::OP_OUT && fin_status == crru_pkg::STAT_OK
			&& type_q == crru_pkg::REQ_UNRANK) |-> (rem_q == '0))
		else $error("unrank left a nonzero remainder");

	a_rank_width: assert property (@(posedge clk) disable iff (!arst_n)
		(op == crru_pkg::OP_OUT && fin_status == crru_pkg::STAT_OK
			&& type_q == crru_pkg::REQ_RANK) |-> ((acc_q >> width_q) == '0))
		else $error("rank does not fit in its rank width");

endmodule
